// ===== design/irdig_pkg.sv =====
// ----------------------------------------------------------------------------
// irdig_pkg
// Shared constants, types and helper functions for the integer to radix
// digits converter.
// ----------------------------------------------------------------------------
`default_nettype none

package irdig_pkg;

    localparam int DEFAULT_VALUE_BITS = 31;
    localparam int RADIX_W            = 5;
    localparam int CHAR_W             = 7;
    localparam int BITS_PER_CYCLE     = 8;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [RADIX_W-1:0] RADIX_MIN      = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX      = 5'd30;
    localparam logic [RADIX_W-1:0] RADIX_RESET    = 5'd10;
    localparam logic [RADIX_W-1:0] DECIMAL_DIGITS = 5'd10;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_A    = 7'd65;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } back_state_t;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] k;
        k = r;
        if (r < RADIX_MIN)
        begin
            k = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            k = RADIX_MAX;
        end
        return k;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DECIMAL_DIGITS)
        begin
            c = ASCII_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = ASCII_A + CHAR_W'(d - DECIMAL_DIGITS);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/irdig_front.sv =====
// ----------------------------------------------------------------------------
// irdig_front
// Holds the radix register, accepts input values and queues each one
// together with the clamped radix it is to be converted with.
// ----------------------------------------------------------------------------
`default_nettype none

module irdig_front #(
    parameter int VALUE_BITS = irdig_pkg::DEFAULT_VALUE_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [irdig_pkg::RADIX_W-1:0] cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [VALUE_BITS-1:0]         value,
    input  wire logic                          q_full,
    output logic                               q_push,
    output logic [VALUE_BITS-1:0]              q_value,
    output logic [irdig_pkg::RADIX_W-1:0]      q_radix
);
    import irdig_pkg::*;

    logic [RADIX_W-1:0] radix_reg;
    logic [RADIX_W-1:0] radix_next;

    assign cfg_ready  = 1'b1;
    assign radix_next = (cfg_valid && cfg_ready) ? cfg_data : radix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign q_value  = value;
    assign q_radix  = clamp_radix(radix_reg);

endmodule

`default_nettype wire

// ===== design/irdig_queue.sv =====
// ----------------------------------------------------------------------------
// irdig_queue
// Two-entry queue carrying a value and its radix from the front to the
// back, so that either side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module irdig_queue #(
    parameter int VALUE_BITS = irdig_pkg::DEFAULT_VALUE_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire logic [VALUE_BITS-1:0]         in_value,
    input  wire logic [irdig_pkg::RADIX_W-1:0] in_radix,
    output logic                               full,
    input  wire logic                          pop,
    output logic                               out_valid,
    output logic [VALUE_BITS-1:0]              out_value,
    output logic [irdig_pkg::RADIX_W-1:0]      out_radix
);
    import irdig_pkg::*;

    localparam int DATA_W  = VALUE_BITS + RADIX_W;
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0]  entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [DATA_W-1:0]  head;

    assign full      = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign out_value = head[VALUE_BITS-1:0];
    assign out_radix = head[DATA_W-1:VALUE_BITS];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= {in_radix, in_value};
        end
    end

endmodule

`default_nettype wire

// ===== design/irdig_back.sv =====
// ----------------------------------------------------------------------------
// irdig_back
// Divides each value repeatedly by its radix, eight quotient bits per cycle,
// stacks the remainders and then emits them most significant digit first
// through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module irdig_back #(
    parameter int VALUE_BITS = irdig_pkg::DEFAULT_VALUE_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire logic [VALUE_BITS-1:0]         q_value,
    input  wire logic [irdig_pkg::RADIX_W-1:0] q_radix,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [irdig_pkg::CHAR_W-1:0]       digit_char,
    output logic                               last_digit
);
    import irdig_pkg::*;

    localparam int CHUNKS   = (VALUE_BITS + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
    localparam int PAD_BITS = CHUNKS * BITS_PER_CYCLE;
    localparam int CHUNK_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int CNT_W    = $clog2(VALUE_BITS + 1);
    localparam int IDX_W    = $clog2(VALUE_BITS);

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [PAD_BITS-1:0]  quo_reg;
    logic [PAD_BITS-1:0]  quo_next;
    logic [RADIX_W-1:0]   rem_reg;
    logic [RADIX_W-1:0]   rem_next;
    logic [RADIX_W-1:0]   radix_reg;
    logic [RADIX_W-1:0]   radix_next;
    logic [CHUNK_W-1:0]   chunk_reg;
    logic [CHUNK_W-1:0]   chunk_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CHAR_W-1:0]    digit_char_reg;
    logic                 last_digit_reg;

    logic [RADIX_W-1:0]   digit_stack [VALUE_BITS];
    logic                 stack_we;
    logic                 out_load;
    logic [CNT_W-1:0]     rd_cnt;
    logic [IDX_W-1:0]     rd_idx;
    logic                 emit_last;

    logic [RADIX_W:0]     part_rem;
    logic [PAD_BITS-1:0]  part_quo;
    logic [RADIX_W-1:0]   div_digit;

    // Restoring division of the current quotient by the radix, one bit per step.
    always_comb
    begin
        part_rem = {1'b0, rem_reg};
        part_quo = quo_reg;
        for (int i = 0; i < BITS_PER_CYCLE; i++)
        begin
            part_rem = {part_rem[RADIX_W-1:0], part_quo[PAD_BITS-1]};
            part_quo = {part_quo[PAD_BITS-2:0], 1'b0};
            if (part_rem >= {1'b0, radix_reg})
            begin
                part_rem    = part_rem - {1'b0, radix_reg};
                part_quo[0] = 1'b1;
            end
        end
    end

    assign div_digit = part_rem[RADIX_W-1:0];
    assign rd_cnt    = cnt_reg - CNT_W'(1);
    assign rd_idx    = rd_cnt[IDX_W-1:0];
    assign emit_last = (cnt_reg == CNT_W'(1));

    always_comb
    begin
        state_next = state_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        radix_next = radix_reg;
        chunk_next = chunk_reg;
        cnt_next   = cnt_reg;
        q_pop      = 1'b0;
        stack_we   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    quo_next   = PAD_BITS'(q_value);
                    radix_next = q_radix;
                    rem_next   = '0;
                    chunk_next = '0;
                    cnt_next   = '0;
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                quo_next = part_quo;
                rem_next = div_digit;
                if (chunk_reg == CHUNK_W'(CHUNKS - 1))
                begin
                    stack_we   = 1'b1;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    chunk_next = '0;
                    rem_next   = '0;
                    if (part_quo == '0)
                    begin
                        state_next = BK_EMIT;
                    end
                end
                else
                begin
                    chunk_next = chunk_reg + CHUNK_W'(1);
                end
            end
            BK_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load = 1'b1;
                    cnt_next = rd_cnt;
                    if (emit_last)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            chunk_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chunk_reg     <= chunk_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            digit_stack[cnt_reg[IDX_W-1:0]] <= div_digit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            digit_char_reg <= digit_to_ascii(digit_stack[rd_idx]);
            last_digit_reg <= emit_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = digit_char_reg;
    assign last_digit = last_digit_reg;

endmodule

`default_nettype wire

// ===== design/integer_to_radix_digits.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits: converts a value to ASCII digits in base 2 to 30.
// Each digit is computed in turn by the shared divider and stacked, then the
// digits are emitted from the stack; the next queued value is started only
// once the last digit is loaded for output. Asynchronous active-low reset.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_radix_digits #(
    parameter int VALUE_BITS = irdig_pkg::DEFAULT_VALUE_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [irdig_pkg::RADIX_W-1:0] cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [VALUE_BITS-1:0]         value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [irdig_pkg::CHAR_W-1:0]       digit_char,
    output logic                               last_digit
);
    import irdig_pkg::*;

    logic                  q_full;
    logic                  q_push;
    logic [VALUE_BITS-1:0] q_in_value;
    logic [RADIX_W-1:0]    q_in_radix;
    logic                  q_valid;
    logic                  q_pop;
    logic [VALUE_BITS-1:0] q_out_value;
    logic [RADIX_W-1:0]    q_out_radix;

    irdig_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_value   (q_in_value),
        .q_radix   (q_in_radix)
    );

    irdig_queue #(
        .VALUE_BITS(VALUE_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .in_value  (q_in_value),
        .in_radix  (q_in_radix),
        .full      (q_full),
        .pop       (q_pop),
        .out_valid (q_valid),
        .out_value (q_out_value),
        .out_radix (q_out_radix)
    );

    irdig_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_value    (q_out_value),
        .q_radix    (q_out_radix),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

endmodule

`default_nettype wire

// ===== design/irdig_checker.sv =====
// ----------------------------------------------------------------------------
// irdig_checker
// Port-level checks on the digit output of the converter, bound to the top
// level.
// ----------------------------------------------------------------------------
`default_nettype none

module irdig_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [irdig_pkg::CHAR_W-1:0]  digit_char,
    input wire logic                          last_digit
);
    import irdig_pkg::*;

    logic out_xfer;
    logic at_start_reg;
    logic at_start_next;

    assign out_xfer      = out_valid && !out_stall;
    assign at_start_next = out_xfer ? last_digit : at_start_reg;

    // A new number starts after reset and after every final digit transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg <= 1'b1;
        end
        else
        begin
            at_start_reg <= at_start_next;
        end
    end

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("digit output dropped valid while stalled");

    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(digit_char) && $stable(last_digit))
        else $error("digit output payload changed while stalled");

    a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((digit_char >= 7'd48) && (digit_char <= 7'd57))
                   || ((digit_char >= 7'd65) && (digit_char <= 7'd84)))
        else $error("digit character outside the legal set");

    a_no_leading_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && at_start_reg && (digit_char == ASCII_ZERO) |-> last_digit)
        else $error("leading zero digit transferred");

endmodule

bind integer_to_radix_digits irdig_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit_char (digit_char),
    .last_digit (last_digit)
);

`default_nettype wire
